/* src/msmr_pkg.sv */
// shared types and constants of the mecanum mixer with speed limit and ramp
package msmr_pkg;

  localparam int COMP_W     = 17;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = 16;
  localparam int PROD_W     = 34;
  localparam int TGT_W      = 19;
  localparam int RAMP_CALC_W = 20;
  localparam int WHEEL_W    = 16;
  localparam int MAXS_W     = 14;
  localparam int RAMP_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_COMP   = 3;
  localparam int NUM_WHEEL  = 4;
  localparam int CNT_W      = 2;
  localparam int STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INCREASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DECREASE = 2'd2;

  localparam logic [MAXS_W-1:0] MAX_SPEED_RST     = 14'd9000;
  localparam logic [RAMP_W-1:0] RAMP_INCREASE_RST = 12'd25;
  localparam logic [RAMP_W-1:0] RAMP_DECREASE_RST = 12'd80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT_START,
    S_SQRT_WAIT,
    S_DIV,
    S_SCL_MUL,
    S_SCL_WR,
    S_MIX,
    S_RAMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_res_t;

endpackage

/* src/msmr_if.sv */
// channel interfaces: velocity command, wheel result and register write
interface msmr_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_x;
  logic signed [15:0] cmd_y;
  logic signed [15:0] cmd_z;
  logic               reset_mode;
  modport source (output valid, cmd_x, cmd_y, cmd_z, reset_mode, input ready);
  modport sink   (input valid, cmd_x, cmd_y, cmd_z, reset_mode, output ready);
endinterface

interface msmr_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel0_cmd;
  logic signed [15:0] wheel1_cmd;
  logic signed [15:0] wheel2_cmd;
  logic signed [15:0] wheel3_cmd;
  logic        [15:0] limited_magnitude;
  modport source (output valid, wheel0_cmd, wheel1_cmd, wheel2_cmd, wheel3_cmd,
                  limited_magnitude, input ready);
  modport sink   (input valid, wheel0_cmd, wheel1_cmd, wheel2_cmd, wheel3_cmd,
                  limited_magnitude, output ready);
endinterface

interface msmr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/msmr_isqrt.sv */
// iterative floor square root, two radicand bits per cycle
module msmr_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [msmr_pkg::SUM_W-1:0]       radicand,
  output msmr_pkg::sqrt_res_t              res
);

  localparam int REM_W  = msmr_pkg::MAG_W + 1;
  localparam int SH_W   = REM_W + 2;
  localparam logic [msmr_pkg::STEP_W-1:0] LAST_STEP = msmr_pkg::STEP_W'(msmr_pkg::MAG_W - 1);

  logic [msmr_pkg::SUM_W-1:0]  rad;
  logic [REM_W-1:0]            rem;
  logic [msmr_pkg::MAG_W-1:0]  root;
  logic [msmr_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;

  logic [SH_W-1:0] rem_sh;
  logic [SH_W-1:0] trial;
  logic [SH_W-1:0] diff;
  logic            take;

  always_comb begin
    rem_sh = {rem, rad[msmr_pkg::SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[msmr_pkg::SUM_W-3:0], 2'b00};
      rem  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[msmr_pkg::MAG_W-2:0], take};
    end
  end

  assign res.done = done;
  assign res.root = root;

endmodule

/* src/mecanum_speed_limit_mix_ramp_top.sv */
// mecanum wheel mixer with 3-d speed limit and per-wheel slew ramp
//
//   channel   role   handshake      payload
//   cmd       sink   valid/ready    cmd_x, cmd_y, cmd_z, reset_mode
//   wheels    source valid/ready    wheel0_cmd..wheel3_cmd, limited_magnitude
//   cfg       sink   valid/ready    index, data (ready always high)
//
// a transaction runs the 16-step square root unit, twice when the limit applies,
// with the 16-step divider and the rescaling of the components between the two runs
// one shared 17x17 multiplier handles squares and scaling, one ramp unit per wheel step
// reset (rst, synchronous) restores register defaults and zeroes the wheel commands
// cmd is taken only when idle; a result waits in the output register under stall
module mecanum_speed_limit_mix_ramp_top (
  input  logic        clk,
  input  logic        rst,
  msmr_cmd_if.sink    cmd,
  msmr_wheel_if.source wheels,
  msmr_cfg_if.sink    cfg
);

  localparam logic [msmr_pkg::CNT_W-1:0]  LAST_COMP  = msmr_pkg::CNT_W'(msmr_pkg::NUM_COMP - 1);
  localparam logic [msmr_pkg::CNT_W-1:0]  LAST_WHEEL = msmr_pkg::CNT_W'(msmr_pkg::NUM_WHEEL - 1);
  localparam logic [msmr_pkg::STEP_W-1:0] LAST_DIV   = msmr_pkg::STEP_W'(msmr_pkg::MAG_W - 1);

  msmr_pkg::state_t state, state_next;

  logic [msmr_pkg::MAXS_W-1:0] max_speed;
  logic [msmr_pkg::RAMP_W-1:0] ramp_increase;
  logic [msmr_pkg::RAMP_W-1:0] ramp_decrease;

  logic signed [msmr_pkg::COMP_W-1:0]  comp [msmr_pkg::NUM_COMP];
  logic signed [msmr_pkg::WHEEL_W-1:0] wheel_cmd [msmr_pkg::NUM_WHEEL];
  logic signed [msmr_pkg::WHEEL_W-1:0] out_wheel [msmr_pkg::NUM_WHEEL];
  logic [msmr_pkg::MAG_W-1:0]          out_lmag;
  logic                                out_valid;

  logic                         rmode;
  logic                         pass;
  logic [msmr_pkg::CNT_W-1:0]   cnt;
  logic [msmr_pkg::STEP_W-1:0]  step_cnt;
  logic [msmr_pkg::SUM_W-1:0]   acc;
  logic [msmr_pkg::PROD_W-1:0]  prod;
  logic [msmr_pkg::MAG_W-1:0]   mag;
  logic [msmr_pkg::MAG_W-1:0]   lmag;
  logic [msmr_pkg::MAG_W-1:0]   rem_d;
  logic [msmr_pkg::MAG_W-1:0]   quo;
  logic signed [msmr_pkg::TGT_W-1:0] tgt;

  // control
  logic accept;
  logic sq_start;
  logic out_free;
  logic out_load;
  msmr_pkg::sqrt_res_t sq_res;

  // datapath
  logic signed [msmr_pkg::COMP_W-1:0] comp_cur;
  logic [msmr_pkg::COMP_W-1:0]        comp_abs;
  logic [msmr_pkg::COMP_W-1:0]        mul_b;
  logic [msmr_pkg::PROD_W-1:0]        mul_p;
  logic [msmr_pkg::COMP_W-1:0]        scl_mag;
  logic signed [msmr_pkg::COMP_W-1:0] scl_val;
  logic [msmr_pkg::MAG_W:0]           div_sh;
  logic [msmr_pkg::MAG_W:0]           div_diff;
  logic                               div_ge;
  logic signed [msmr_pkg::TGT_W-1:0]  mx, my, mz, tgt_next;
  logic                               sy_pos, sx_pos;
  logic signed [msmr_pkg::RAMP_CALC_W-1:0] rt, rc, aset, acur, rstep, cand, clamped;
  logic signed [msmr_pkg::WHEEL_W-1:0] ramp_res;

  msmr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .res      (sq_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      msmr_pkg::S_IDLE:       if (cmd.valid) state_next = msmr_pkg::S_SQ_MUL;
      msmr_pkg::S_SQ_MUL:     state_next = msmr_pkg::S_SQ_ACC;
      msmr_pkg::S_SQ_ACC:     state_next = (cnt == LAST_COMP) ? msmr_pkg::S_SQRT_START
                                                              : msmr_pkg::S_SQ_MUL;
      msmr_pkg::S_SQRT_START: state_next = msmr_pkg::S_SQRT_WAIT;
      msmr_pkg::S_SQRT_WAIT: begin
        if (sq_res.done) begin
          if (!pass && (sq_res.root > msmr_pkg::MAG_W'(max_speed))) begin
            state_next = msmr_pkg::S_DIV;
          end else begin
            state_next = msmr_pkg::S_MIX;
          end
        end
      end
      msmr_pkg::S_DIV:        if (step_cnt == LAST_DIV) state_next = msmr_pkg::S_SCL_MUL;
      msmr_pkg::S_SCL_MUL:    state_next = msmr_pkg::S_SCL_WR;
      msmr_pkg::S_SCL_WR:     state_next = (cnt == LAST_COMP) ? msmr_pkg::S_SQ_MUL
                                                              : msmr_pkg::S_SCL_MUL;
      msmr_pkg::S_MIX:        state_next = msmr_pkg::S_RAMP;
      msmr_pkg::S_RAMP:       state_next = (cnt == LAST_WHEEL) ? msmr_pkg::S_OUT
                                                               : msmr_pkg::S_MIX;
      msmr_pkg::S_OUT:        if (out_free) state_next = msmr_pkg::S_IDLE;
      default:                state_next = msmr_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd.ready = (state == msmr_pkg::S_IDLE);
    accept    = cmd.valid && cmd.ready;
    sq_start  = (state == msmr_pkg::S_SQRT_START);
    out_free  = !out_valid || wheels.ready;
    out_load  = (state == msmr_pkg::S_OUT) && out_free;
  end

  assign cfg.ready = 1'b1;

  // shared multiplier, divider step, mixer and ramp
  always_comb begin
    comp_cur = (cnt == LAST_WHEEL) ? '0 : comp[cnt];
    comp_abs = comp_cur[msmr_pkg::COMP_W-1] ? msmr_pkg::COMP_W'(-comp_cur)
                                            : msmr_pkg::COMP_W'(comp_cur);
    mul_b    = (state == msmr_pkg::S_SCL_MUL) ? {1'b0, quo} : comp_abs;
    mul_p    = msmr_pkg::PROD_W'(comp_abs) * msmr_pkg::PROD_W'(mul_b);

    scl_mag  = prod[msmr_pkg::MAG_W +: msmr_pkg::COMP_W];
    scl_val  = comp_cur[msmr_pkg::COMP_W-1] ? -$signed(scl_mag) : $signed(scl_mag);

    div_sh   = {rem_d, 1'b0};
    div_ge   = div_sh >= {1'b0, mag};
    div_diff = div_sh - {1'b0, mag};

    mx = rmode ? '0 : msmr_pkg::TGT_W'(comp[0]);
    my = rmode ? '0 : msmr_pkg::TGT_W'(comp[1]);
    mz = rmode ? '0 : msmr_pkg::TGT_W'(comp[2]);
    // wheel sign pattern: y positive on wheels 0 and 3, x positive on wheels 0 and 1
    sy_pos   = (cnt == 2'd0) || (cnt == 2'd3);
    sx_pos   = (cnt == 2'd0) || (cnt == 2'd1);
    tgt_next = (sy_pos ? my : -my) + (sx_pos ? mx : -mx) - mz;

    rt    = msmr_pkg::RAMP_CALC_W'(tgt);
    rc    = msmr_pkg::RAMP_CALC_W'(wheel_cmd[cnt]);
    aset  = rt[msmr_pkg::RAMP_CALC_W-1] ? -rt : rt;
    acur  = rc[msmr_pkg::RAMP_CALC_W-1] ? -rc : rc;
    rstep = (aset >= acur) ? $signed({8'd0, ramp_increase}) : $signed({8'd0, ramp_decrease});
    if (rt > rc) begin
      cand    = rc + rstep;
      clamped = (cand > rt) ? rt : cand;
    end else begin
      cand    = rc - rstep;
      clamped = (cand < rt) ? rt : cand;
    end
    if (clamped > 20'sd32767) begin
      ramp_res = 16'sh7fff;
    end else if (clamped < -20'sd32768) begin
      ramp_res = 16'sh8000;
    end else begin
      ramp_res = clamped[msmr_pkg::WHEEL_W-1:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= msmr_pkg::S_IDLE;
      out_valid     <= 1'b0;
      max_speed     <= msmr_pkg::MAX_SPEED_RST;
      ramp_increase <= msmr_pkg::RAMP_INCREASE_RST;
      ramp_decrease <= msmr_pkg::RAMP_DECREASE_RST;
      for (int i = 0; i < msmr_pkg::NUM_WHEEL; i++) begin
        wheel_cmd[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (wheels.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          msmr_pkg::REG_MAX_SPEED:     max_speed     <= cfg.data[msmr_pkg::MAXS_W-1:0];
          msmr_pkg::REG_RAMP_INCREASE: ramp_increase <= cfg.data[msmr_pkg::RAMP_W-1:0];
          msmr_pkg::REG_RAMP_DECREASE: ramp_decrease <= cfg.data[msmr_pkg::RAMP_W-1:0];
          default: ;
        endcase
      end
      if (state == msmr_pkg::S_RAMP) begin
        wheel_cmd[cnt] <= ramp_res;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      msmr_pkg::S_IDLE: begin
        if (accept) begin
          comp[0] <= msmr_pkg::COMP_W'(cmd.cmd_x);
          comp[1] <= -msmr_pkg::COMP_W'(cmd.cmd_y);
          comp[2] <= -msmr_pkg::COMP_W'(cmd.cmd_z);
          rmode   <= cmd.reset_mode;
          acc     <= '0;
          cnt     <= '0;
          pass    <= 1'b0;
        end
      end
      msmr_pkg::S_SQ_MUL, msmr_pkg::S_SCL_MUL: prod <= mul_p;
      msmr_pkg::S_SQ_ACC: begin
        acc <= acc + prod[msmr_pkg::SUM_W-1:0];
        cnt <= (cnt == LAST_COMP) ? '0 : cnt + 1'b1;
      end
      msmr_pkg::S_SQRT_WAIT: begin
        if (sq_res.done) begin
          lmag     <= sq_res.root;
          cnt      <= '0;
          if (!pass) begin
            mag      <= sq_res.root;
            rem_d    <= msmr_pkg::MAG_W'(max_speed);
            step_cnt <= '0;
          end
        end
      end
      msmr_pkg::S_DIV: begin
        rem_d    <= div_ge ? div_diff[msmr_pkg::MAG_W-1:0] : div_sh[msmr_pkg::MAG_W-1:0];
        quo      <= {quo[msmr_pkg::MAG_W-2:0], div_ge};
        step_cnt <= step_cnt + 1'b1;
      end
      msmr_pkg::S_SCL_WR: begin
        comp[cnt] <= scl_val;
        if (cnt == LAST_COMP) begin
          cnt  <= '0;
          pass <= 1'b1;
          acc  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      msmr_pkg::S_MIX:  tgt <= tgt_next;
      msmr_pkg::S_RAMP: cnt <= cnt + 1'b1;
      msmr_pkg::S_OUT: begin
        if (out_load) begin
          for (int i = 0; i < msmr_pkg::NUM_WHEEL; i++) begin
            out_wheel[i] <= wheel_cmd[i];
          end
          out_lmag <= lmag;
        end
      end
      default: ;
    endcase
  end

  assign wheels.valid             = out_valid;
  assign wheels.wheel0_cmd        = out_wheel[0];
  assign wheels.wheel1_cmd        = out_wheel[1];
  assign wheels.wheel2_cmd        = out_wheel[2];
  assign wheels.wheel3_cmd        = out_wheel[3];
  assign wheels.limited_magnitude = out_lmag;

`ifndef SYNTHESIS
  // the root unit reports only while the sequencer waits for it
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_res.done |-> state == msmr_pkg::S_SQRT_WAIT)
    else $error("square root done outside wait state");

  // a new command is never taken on the cycle after one was taken
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("command accepted while busy");

  // a finished result lands in the output register
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> wheels.valid && state == msmr_pkg::S_IDLE)
    else $error("result not presented after load");

  // the divider runs only after the magnitude was found above the limit
  a_div_needs_limit: assert property (@(posedge clk) disable iff (rst)
    (state == msmr_pkg::S_DIV) |-> (mag > msmr_pkg::MAG_W'(max_speed)) && !pass)
    else $error("divider active without limiting");
`endif

endmodule

/* dv/tb_top.sv */
// self-checking bench for the mecanum mixer: predicts wheel commands and limited magnitude
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [msmr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [msmr_pkg::NUM_WHEEL-1:0][msmr_pkg::WHEEL_W-1:0] wheel;
    logic [msmr_pkg::MAG_W-1:0]                            magnitude;
  } wheel_res_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  class mixer_scoreboard;
    logic [msmr_pkg::MAXS_W-1:0] max_speed;
    logic [msmr_pkg::RAMP_W-1:0] ramp_inc;
    logic [msmr_pkg::RAMP_W-1:0] ramp_dec;
    int                          wheel_q[msmr_pkg::NUM_WHEEL];
    wheel_res_t                  expected_wheels[$];
    int                          mismatches;

    function new();
      max_speed  = msmr_pkg::MAX_SPEED_RST;
      ramp_inc   = msmr_pkg::RAMP_INCREASE_RST;
      ramp_dec   = msmr_pkg::RAMP_DECREASE_RST;
      mismatches = 0;
      foreach (wheel_q[i]) wheel_q[i] = 0;
    endfunction

    function void write_reg(logic [msmr_pkg::CFG_IDX_W-1:0] idx,
                            logic [msmr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        msmr_pkg::REG_MAX_SPEED:     max_speed = data[msmr_pkg::MAXS_W-1:0];
        msmr_pkg::REG_RAMP_INCREASE: ramp_inc  = data[msmr_pkg::RAMP_W-1:0];
        msmr_pkg::REG_RAMP_DECREASE: ramp_dec  = data[msmr_pkg::RAMP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n   = n - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe = probe >> 2;
      end
      return res;
    endfunction

    function longint unsigned sum_sq(int a, int b, int c);
      longint s;
      s = longint'(a) * a + longint'(b) * b + longint'(c) * c;
      return s;
    endfunction

    // magnitude times scale, shifted down, sign restored: truncates toward zero
    function int shrink(int v, longint unsigned scale);
      longint unsigned m;
      longint unsigned p;
      m = 64'((v < 0) ? -v : v);
      p = (m * scale) >> 16;
      return (v < 0) ? -int'(p) : int'(p);
    endfunction

    function int slew(int target, int cur);
      int step;
      int c;
      step = (((target < 0) ? -target : target) >= ((cur < 0) ? -cur : cur)) ?
             int'(ramp_inc) : int'(ramp_dec);
      if (target > cur) begin
        c = cur + step;
        if (c > target) c = target;
      end else begin
        c = cur - step;
        if (c < target) c = target;
      end
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      return c;
    endfunction

    function void note_command(logic signed [15:0] cx, logic signed [15:0] cy,
                               logic signed [15:0] cz, logic rm);
      int              x;
      int              y;
      int              z;
      int              tgt[msmr_pkg::NUM_WHEEL];
      longint unsigned mag;
      longint unsigned scale;
      wheel_res_t      res;
      x = int'(cx);
      y = int'(cy);
      y = -y;
      z = int'(cz);
      z = -z;
      mag = floor_root(sum_sq(x, y, z));
      if (mag > max_speed) begin
        scale = (longint'(max_speed) << 16) / mag;
        x = shrink(x, scale);
        y = shrink(y, scale);
        z = shrink(z, scale);
      end
      // magnitude is reported before the reset flag clears the components
      res.magnitude = msmr_pkg::MAG_W'(floor_root(sum_sq(x, y, z)));
      if (rm) begin
        x = 0;
        y = 0;
        z = 0;
      end
      tgt[0] = y + x - z;
      tgt[1] = -y + x - z;
      tgt[2] = -y - x - z;
      tgt[3] = y - x - z;
      for (int i = 0; i < msmr_pkg::NUM_WHEEL; i++) begin
        wheel_q[i]   = slew(tgt[i], wheel_q[i]);
        res.wheel[i] = msmr_pkg::WHEEL_W'(wheel_q[i]);
      end
      expected_wheels.push_back(res);
    endfunction

    function void check_wheels(wheel_res_t got);
      wheel_res_t want;
      if (expected_wheels.size() == 0) begin
        mismatches++;
        $display("%0t: wheel transaction with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_wheels.pop_front();
      for (int i = 0; i < msmr_pkg::NUM_WHEEL; i++) begin
        if (got.wheel[i] !== want.wheel[i]) begin
          mismatches++;
          $display("%0t: wheel%0d_cmd expected %0d actual %0d", $time, i,
                   $signed(want.wheel[i]), $signed(got.wheel[i]));
        end
      end
      if (got.magnitude !== want.magnitude) begin
        mismatches++;
        $display("%0t: limited_magnitude expected %0d actual %0d", $time,
                 want.magnitude, got.magnitude);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   hold_req;
  int   burst_left;

  msmr_cmd_if   cmd_ch();
  msmr_wheel_if wheel_ch();
  msmr_cfg_if   cfg_ch();

  mixer_scoreboard mix_sb = new();

  mecanum_speed_limit_mix_ramp_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .wheels (wheel_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready)
      mix_sb.write_reg(cfg_ch.index, cfg_ch.data);
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      mix_sb.note_command(cmd_ch.cmd_x, cmd_ch.cmd_y, cmd_ch.cmd_z, cmd_ch.reset_mode);
    if (!rst && wheel_ch.valid && wheel_ch.ready)
      mix_sb.check_wheels({wheel_ch.wheel3_cmd, wheel_ch.wheel2_cmd, wheel_ch.wheel1_cmd,
                           wheel_ch.wheel0_cmd, wheel_ch.limited_magnitude});
  end

  // receiver back-pressure
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       stall_left;
    int       hold_left;
    bit       hold_seen;
    rx_mode    = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 1'b0;
    wheel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        wheel_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   wheel_ch.ready <= 1'b1;
          RX_COIN:   wheel_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: wheel_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              wheel_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(5, 40);
              wheel_ch.ready <= 1'b0;
            end else begin
              wheel_ch.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 15);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z, input logic rm);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd_x      <= x;
    cmd_ch.cmd_y      <= y;
    cmd_ch.cmd_z      <= z;
    cmd_ch.reset_mode <= rm;
    do @(posedge clk); while (!cmd_ch.ready);
    pace();
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (mix_sb.expected_wheels.size() != 0);
  endtask

  task automatic put_reg(input logic [msmr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [msmr_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // upper data bits are junk; the block keeps only the register width
  task automatic load_regs(input logic [msmr_pkg::MAXS_W-1:0] ms,
                           input logic [msmr_pkg::RAMP_W-1:0] ri,
                           input logic [msmr_pkg::RAMP_W-1:0] rd, input bit spare);
    put_reg(msmr_pkg::REG_MAX_SPEED, {2'($urandom), ms});
    put_reg(msmr_pkg::REG_RAMP_INCREASE, {4'($urandom), ri});
    if (spare) put_reg(REG_SPARE, 16'($urandom));
    put_reg(msmr_pkg::REG_RAMP_DECREASE, {4'($urandom), rd});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_speed();
    int v;
    case ($urandom_range(0, 7))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = 0;
      3:       v = -1;
      4, 5:    v = $urandom_range(0, 4000) - 2000;
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  initial begin
    logic signed [15:0]          rx;
    logic signed [15:0]          ry;
    logic signed [15:0]          rz;
    logic                        rr;
    logic [msmr_pkg::MAXS_W-1:0] ms;
    logic [msmr_pkg::RAMP_W-1:0] ri;
    logic [msmr_pkg::RAMP_W-1:0] rd;
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.cmd_x      <= '0;
    cmd_ch.cmd_y      <= '0;
    cmd_ch.cmd_z      <= '0;
    cmd_ch.reset_mode <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    send_cmd(0, 0, 0, 0);
    send_cmd(32767, 0, 0, 0);
    send_cmd(-32768, 0, 0, 0);
    send_cmd(0, -32768, 0, 0);
    send_cmd(0, 0, -32768, 0);
    send_cmd(-32768, -32768, -32768, 0);
    send_cmd(32767, 32767, 32767, 0);
    send_cmd(32767, 32767, 32767, 1);
    send_cmd(1000, -2000, 300, 0);
    send_cmd(9000, 0, 0, 0);
    send_cmd(9001, 0, 0, 0);
    drain_results();

    // widest limit and steps, plus a write to the unused index
    load_regs(14'h3FFF, 12'hFFF, 12'hFFF, 1'b1);
    repeat (3) send_cmd(32767, -32768, -32768, 0);
    send_cmd(0, 0, 0, 1);
    repeat (3) send_cmd(-32768, 32767, 32767, 0);
    drain_results();

    // zero limit and zero steps: wheels hold
    load_regs(0, 0, 0, 1'b0);
    send_cmd(100, 200, 300, 0);
    send_cmd(0, 0, 0, 0);
    send_cmd(-5, 7, 9, 1);
    drain_results();

    load_regs(4000, 0, 100, 1'b0);
    send_cmd(0, 0, 0, 0);
    send_cmd(0, 0, 0, 1);
    send_cmd(20000, 0, 0, 0);

    rx = 0;
    ry = 0;
    rz = 0;
    rr = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin
          ms = 14'h3FFF; ri = 12'($urandom); rd = 12'($urandom);
        end
        1: begin
          ms = 14'($urandom); ri = 12'hFFF; rd = 0;
        end
        2: begin
          ms = 14'($urandom_range(0, 16383));
          ri = 12'($urandom_range(1, 200));
          rd = 12'($urandom_range(1, 400));
        end
        3: begin
          ms = 1; ri = 0; rd = 12'hFFF;
        end
        4: begin
          ms = 14'($urandom_range(0, 3000)); ri = 12'($urandom_range(1, 300));
          rd = 12'($urandom);
        end
        default: begin
          ms = 14'($urandom); ri = 12'($urandom); rd = 12'($urandom);
        end
      endcase
      load_regs(ms, ri, rd, 1'($urandom_range(0, 1)));
      for (int n = 0; n < 105; n++) begin
        if (ph == 1 && n == 40) hold_req = 1'b1;
        if (ph == 3 && n == 50) drain_results();
        // repeated commands let the ramp settle on its target
        if ($urandom_range(0, 9) >= 3) begin
          rx = pick_speed();
          ry = pick_speed();
          rz = pick_speed();
          rr = ($urandom_range(0, 9) == 0);
        end
        send_cmd(rx, ry, rz, rr);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mix_sb.mismatches == 0 && mix_sb.expected_wheels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/msmr_pkg.sv
src/msmr_if.sv
src/msmr_isqrt.sv
src/mecanum_speed_limit_mix_ramp_top.sv
dv/tb_top.sv
